[src/i2cm_pkg.sv]
// Shared types and constants for the I2C master register access unit.
// No dependencies.
`default_nettype none
package i2cm_pkg;
  localparam int WRITE_DEPTH_DEF = 16;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] WAIT_MAX = 16'hffff;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_COUNT   = 2'd2;

  localparam logic [0:0] CFG_REG_EN  = 1'd0;
  localparam logic [0:0] CFG_TIMEOUT = 1'd1;

  typedef enum logic [1:0] {
    KIND_ADDR_W = 2'd0, KIND_REG = 2'd1, KIND_ADDR_R = 2'd2, KIND_DATA = 2'd3
  } kind_t;

  typedef enum logic [15:0] {
    PH_IDLE  = 16'h0001, PH_START1 = 16'h0002, PH_START2 = 16'h0004,
    PH_TXL   = 16'h0008, PH_TXH    = 16'h0010, PH_ACKL   = 16'h0020,
    PH_ACKW  = 16'h0040, PH_GAP    = 16'h0080, PH_RS1    = 16'h0100,
    PH_RXL   = 16'h0200, PH_RXH    = 16'h0400, PH_MAL    = 16'h0800,
    PH_MAH   = 16'h1000, PH_STOP1  = 16'h2000, PH_STOP2  = 16'h4000,
    PH_STOP3 = 16'h8000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       sda_in;
    logic       is_read;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
  } word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic [1:0] status;
  } res_t;
endpackage
`default_nettype wire

[src/i2cm_front.sv]
// Input stage: accepts words and holds them in a two-entry queue.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_front import i2cm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire word_t in_word,
  output logic       q_valid,
  output word_t      q_word,
  input  wire logic  q_take
);
  word_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_take;
  assign q_valid = (count != 2'd0);
  assign q_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_word;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop of empty queue");
endmodule
`default_nettype wire

[src/i2cm_back.sv]
// Bus sequencer: executes one queued word per cycle into a result register, unless out_ready stalls the result.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_back import i2cm_pkg::*; #(
  parameter int WRITE_DEPTH = WRITE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire word_t       q_word,
  output logic             q_take,
  input  wire logic        reg_en,
  input  wire logic [15:0] ack_timeout,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res
);
  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int FW = $clog2(WRITE_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(WRITE_DEPTH);

  logic [7:0] wbuf [WRITE_DEPTH];
  phase_t phase, phase_next;
  kind_t  kind, kind_next;
  logic [3:0]  bit_index, bit_next;
  logic [7:0]  shift_register, shift_next;
  logic [7:0]  bytes_left, left_next;
  logic [15:0] wait_counter, wait_next;
  logic [FW-1:0] write_fill, fill_next, data_pos, pos_next;
  logic [14:0] latched_command, cmd_next;
  logic        rd_latched, rd_next;
  logic        scl, sda, scl_next, sda_next;
  logic [1:0]  pending, pending_next;
  logic [7:0]  buf_rd;
  res_t        res;
  logic        idle;
  logic        wr_en;
  logic [15:0] wait_inc;

  assign q_take = q_valid && (!out_valid || out_ready);
  assign idle = (phase == PH_IDLE);
  assign wait_inc = (wait_counter < WAIT_MAX) ? wait_counter + 16'd1 : wait_counter;
  assign wr_en = q_take && q_word.req_type == REQ_LOAD && idle && write_fill < FULL;

  always_comb begin
    phase_next = phase; kind_next = kind; bit_next = bit_index;
    shift_next = shift_register; left_next = bytes_left; wait_next = wait_counter;
    fill_next = write_fill; pos_next = data_pos; cmd_next = latched_command;
    rd_next = rd_latched; scl_next = scl; sda_next = sda; pending_next = pending;
    res = '0;
    case (q_word.req_type)
      REQ_LOAD: if (wr_en) fill_next = write_fill + FW'(1);
      REQ_CMD: if (idle) begin
        if (!q_word.is_read && {{(FW > 8 ? FW - 8 : 0){1'b0}}, q_word.byte_count}
            > {{(FW > 8 ? 0 : 8 - FW){1'b0}}, write_fill}) begin
          res.done_res = 1'b1;
          res.status = ST_COUNT;
          fill_next = '0;
        end else begin
          cmd_next = {q_word.register_address, q_word.slave_address};
          rd_next = q_word.is_read;
          left_next = q_word.byte_count;
          pos_next = '0;
          pending_next = ST_OK;
          wait_next = '0;
          shift_next = {q_word.slave_address, 1'b0};
          bit_next = '0;
          kind_next = KIND_ADDR_W;
          phase_next = PH_START1;
        end
      end
      REQ_TICK: begin
        case (phase)
          PH_IDLE: ;
          PH_START1: begin scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_START2; end
          PH_START2: begin scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_TXL; end
          PH_TXL: begin scl_next = 1'b0; sda_next = shift_register[7]; phase_next = PH_TXH; end
          PH_TXH: begin
            scl_next = 1'b1; sda_next = shift_register[7];
            shift_next = {shift_register[6:0], 1'b0};
            bit_next = bit_index + 4'd1;
            phase_next = (bit_index + 4'd1 >= 4'd8) ? PH_ACKL : PH_TXL;
          end
          PH_ACKL: begin
            scl_next = 1'b0; sda_next = 1'b1; wait_next = '0; phase_next = PH_ACKW;
          end
          PH_ACKW: begin
            scl_next = 1'b1; sda_next = 1'b1;
            if (!q_word.sda_in) begin
              case (kind)
                KIND_ADDR_W, KIND_REG: begin
                  if (kind == KIND_ADDR_W && reg_en) begin
                    shift_next = latched_command[14:7]; bit_next = '0;
                    kind_next = KIND_REG; phase_next = PH_TXL;
                  end else if (rd_latched) begin
                    phase_next = PH_RS1;
                  end else if (bytes_left == 8'd0 || data_pos >= FULL) begin
                    phase_next = PH_STOP1;
                  end else begin
                    shift_next = buf_rd; bit_next = '0; kind_next = KIND_DATA;
                    phase_next = PH_TXL; pos_next = data_pos + FW'(1);
                  end
                end
                KIND_ADDR_R: begin
                  if (bytes_left == 8'd0) phase_next = PH_STOP1;
                  else begin
                    shift_next = '0; bit_next = '0; phase_next = PH_RXL;
                  end
                end
                default: begin
                  if (bytes_left != 8'd0) left_next = bytes_left - 8'd1;
                  phase_next = PH_GAP;
                end
              endcase
            end else begin
              wait_next = wait_inc;
              if (wait_inc >= ack_timeout) begin
                pending_next = ST_TIMEOUT; phase_next = PH_STOP1;
              end
            end
          end
          PH_GAP: begin
            scl_next = 1'b0; sda_next = 1'b1;
            if (bytes_left == 8'd0 || data_pos >= FULL) phase_next = PH_STOP1;
            else begin
              shift_next = buf_rd; bit_next = '0; kind_next = KIND_DATA;
              phase_next = PH_TXL; pos_next = data_pos + FW'(1);
            end
          end
          PH_RS1: begin
            scl_next = 1'b0; sda_next = 1'b1;
            shift_next = {latched_command[6:0], 1'b1}; bit_next = '0;
            kind_next = KIND_ADDR_R; phase_next = PH_START1;
          end
          PH_RXL: begin scl_next = 1'b0; sda_next = 1'b1; phase_next = PH_RXH; end
          PH_RXH: begin
            scl_next = 1'b1; sda_next = 1'b1;
            shift_next = {shift_register[6:0], q_word.sda_in};
            bit_next = bit_index + 4'd1;
            if (bit_index + 4'd1 >= 4'd8) begin
              res.read_valid = 1'b1;
              res.read_data = {shift_register[6:0], q_word.sda_in};
              if (bytes_left != 8'd0) left_next = bytes_left - 8'd1;
              phase_next = PH_MAL;
            end else phase_next = PH_RXL;
          end
          PH_MAL: begin
            scl_next = 1'b0; sda_next = (bytes_left == 8'd0); phase_next = PH_MAH;
          end
          PH_MAH: begin
            scl_next = 1'b1; sda_next = (bytes_left == 8'd0);
            if (bytes_left == 8'd0) phase_next = PH_STOP1;
            else begin
              shift_next = '0; bit_next = '0; phase_next = PH_RXL;
            end
          end
          PH_STOP1: begin scl_next = 1'b0; sda_next = 1'b0; phase_next = PH_STOP2; end
          PH_STOP2: begin scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_STOP3; end
          PH_STOP3: begin
            scl_next = 1'b1; sda_next = 1'b1;
            res.done_res = 1'b1; res.status = pending;
            if (!rd_latched) fill_next = '0;
            phase_next = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    res.scl_level = scl_next;
    res.sda_level = sda_next;
    res.busy_res = (phase_next != PH_IDLE);
  end

  // Prefetch the next write byte; data_pos settles well before its use.
  always_ff @(posedge clk) begin
    if (wr_en) wbuf[write_fill[AW-1:0]] <= q_word.data_byte;
    buf_rd <= wbuf[data_pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_take) out_res <= res;
    if (rst) begin
      phase <= PH_IDLE; kind <= KIND_ADDR_W; bit_index <= '0; shift_register <= '0;
      bytes_left <= '0; wait_counter <= '0; write_fill <= '0; data_pos <= '0;
      latched_command <= '0; rd_latched <= 1'b0; scl <= 1'b1; sda <= 1'b1;
      pending <= ST_OK; out_valid <= 1'b0;
    end else begin
      if (q_take) begin
        phase <= phase_next; kind <= kind_next; bit_index <= bit_next;
        shift_register <= shift_next; bytes_left <= left_next; wait_counter <= wait_next;
        write_fill <= fill_next; data_pos <= pos_next; latched_command <= cmd_next;
        rd_latched <= rd_next; scl <= scl_next; sda <= sda_next; pending <= pending_next;
      end
      if (q_take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    write_fill <= FULL) else $error("write fill beyond depth");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_res)) else $error("result lost");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    q_take && res.done_res |=> phase == PH_IDLE) else $error("done while busy");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase)) else $error("phase not one-hot");
endmodule
`default_nettype wire

[src/i2c_master_register_access_unit.sv]
// Top level of the I2C master register access unit.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
// Flow: a word accepted into the queue leaves it when the sequencer takes it, and its
// result is then registered in out_res, when out_valid rises.
// Throughput: one word per cycle while out_ready does not stall the result register.
// Reset: synchronous, clears queue and sequencer (idle, lines released), sets config to defaults.
`default_nettype none
module i2c_master_register_access_unit import i2cm_pkg::*; #(
  parameter int WRITE_DEPTH = WRITE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic        sda_in,
  input  wire logic        is_read,
  input  wire logic [6:0]  slave_address,
  input  wire logic [7:0]  register_address,
  input  wire logic [7:0]  byte_count,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             scl_level,
  output logic             sda_level,
  output logic             busy_res,
  output logic             read_valid,
  output logic [7:0]       read_data,
  output logic             done_res,
  output logic [1:0]       status
);
  word_t in_word, q_word;
  res_t  res;
  logic  q_valid, q_take;
  logic  reg_en;
  logic [15:0] ack_timeout;

  // Config registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_en <= 1'b1;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REG_EN:  reg_en <= cfg_data[0];
        CFG_TIMEOUT: ack_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_word = '{req_type, sda_in, is_read, slave_address,
                     register_address, byte_count, data_byte};

  i2cm_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_word,
    .q_valid, .q_word, .q_take
  );

  i2cm_back #(.WRITE_DEPTH(WRITE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_word, .q_take, .reg_en, .ack_timeout,
    .out_valid, .out_ready, .out_res(res)
  );

  assign scl_level = res.scl_level;
  assign sda_level = res.sda_level;
  assign busy_res = res.busy_res;
  assign read_valid = res.read_valid;
  assign read_data = res.read_data;
  assign done_res = res.done_res;
  assign status = res.status;
endmodule
`default_nettype wire
